@@ src/trackball_pad_port_unit_assert.svh @@
// Assertion macros used by the checker of this block
`ifndef TRACKBALL_PAD_PORT_UNIT_ASSERT_SVH
`define TRACKBALL_PAD_PORT_UNIT_ASSERT_SVH

// checked only outside reset
`define TBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TBP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tbp_pkg.sv @@
package tbp_pkg;

	// item opcodes
	localparam logic [1:0] OP_MOTION = 2'd0;
	localparam logic [1:0] OP_CTRL   = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// read targets
	localparam logic [2:0] OBJ_A     = 3'd0;
	localparam logic [2:0] OBJ_B     = 3'd1;
	localparam logic [2:0] OBJ_UP    = 3'd2;
	localparam logic [2:0] OBJ_RIGHT = 3'd5;

	// configuration register indexes
	localparam logic REG_REGION_JAPAN = 1'b0;
	localparam logic REG_PORT_INDEX   = 1'b1;

	// control register codes
	localparam logic [7:0] CTRL_P0_HI = 8'h0d;
	localparam logic [7:0] CTRL_P0_LO = 8'h2d;
	localparam logic [7:0] CTRL_P1_HI = 8'h07;
	localparam logic [7:0] CTRL_P1_LO = 8'h87;

	// strobe sequencing
	localparam logic [7:0] STROBE_WRAP = 8'd190;
	localparam logic [2:0] LAST_PHASE  = 3'd4;

	// export velocity shaping
	typedef logic signed [9:0] vel_t;
	localparam vel_t VEL_LIMIT = 10'sd50;
	localparam vel_t VEL_KNEE  = 10'sd15;
	localparam vel_t VEL_PULL  = 10'sd5;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [2:0]        object_id;
		logic              button_a;
		logic              button_b;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic [7:0]        ctrl_value;
		logic [7:0]        ctrl_prev;
		logic [7:0]        port_dc;
		logic [7:0]        port_dd;
	} item_t;

endpackage

@@ src/tbp_in_stage.sv @@
module tbp_in_stage
	import tbp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  out_free,
	output logic  fire,
	output item_t item_s1
);

	logic valid_s1;
	logic adv;

	// only a read needs room at the output
	assign adv      = !valid_s1 || (item_s1.opcode != OP_READ) || out_free;
	assign in_stall = valid_s1 && !adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

@@ src/tbp_engine.sv @@
module tbp_engine
	import tbp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  logic  cfg_index,
	input  logic  cfg_data,
	input  logic  fire,
	input  item_t item_s1,
	output logic  bit_c
);

	logic       region_japan_q;
	logic       port_index_q;
	logic [7:0] axis_x_q;
	logic [7:0] axis_y_q;
	logic       axis_latch_q;
	logic [7:0] strobe_clock_q;
	logic [2:0] strobe_phase_q;

	logic       latch_n;
	logic [7:0] dir;
	logic [3:0] nib;
	logic       b4;
	logic       b5;
	logic [1:0] sel;

	// trackball velocity: cur minus half of mv (truncated), clamped, eased toward zero
	function automatic logic [7:0] velocity(input logic [7:0] cur, input logic signed [7:0] mv);
		vel_t mv_e;
		vel_t half;
		vel_t v;
		mv_e = vel_t'(mv);
		half = (mv_e + vel_t'({1'b0, mv[7]})) >>> 1;
		v    = vel_t'($signed(cur)) - half;
		if (v > VEL_LIMIT)
			v = VEL_LIMIT;
		else if (v < -VEL_LIMIT)
			v = -VEL_LIMIT;
		if (v > 10'sd0)
			v = v - 10'sd1;
		if (v < 10'sd0)
			v = v + 10'sd1;
		if (v >= VEL_KNEE)
			v = v - VEL_PULL;
		else if (v <= -VEL_KNEE)
			v = v + VEL_PULL;
		return v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_japan_q <= 1'b0;
			port_index_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REGION_JAPAN: region_japan_q <= cfg_data;
				REG_PORT_INDEX:   port_index_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		latch_n = axis_latch_q;
		if (item_s1.ctrl_prev[3:0] != item_s1.ctrl_value[3:0])
			latch_n = 1'b1;
		if (item_s1.ctrl_value == CTRL_P0_HI && !port_index_q)
			latch_n = !latch_n;
		if (item_s1.ctrl_value == CTRL_P1_HI && port_index_q)
			latch_n = !latch_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q       <= 8'd0;
			axis_y_q       <= 8'd0;
			axis_latch_q   <= 1'b1;
			strobe_clock_q <= 8'd0;
			strobe_phase_q <= 3'd0;
		end else if (fire) begin
			case (item_s1.opcode)
				OP_MOTION: begin
					if (region_japan_q) begin
						axis_x_q <= axis_x_q + item_s1.move_x;
						axis_y_q <= axis_y_q + item_s1.move_y;
					end else begin
						axis_x_q <= velocity(axis_x_q, item_s1.move_x);
						axis_y_q <= velocity(axis_y_q, item_s1.move_y);
					end
				end
				OP_CTRL: begin
					axis_latch_q <= latch_n;
				end
				OP_TICK: begin
					if (strobe_clock_q >= STROBE_WRAP) begin
						strobe_clock_q <= 8'd0;
						strobe_phase_q <= (strobe_phase_q >= LAST_PHASE) ? 3'd0
							: strobe_phase_q + 3'd1;
					end else begin
						strobe_clock_q <= strobe_clock_q + 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// read path
	assign dir = axis_latch_q ? axis_y_q : axis_x_q;
	assign sel = 2'(item_s1.object_id - OBJ_UP);

	always_comb begin
		nib = 4'hf;
		b4  = 1'b1;
		b5  = 1'b1;
		if (region_japan_q) begin
			case (strobe_phase_q)
				3'd0: nib = {2'b00, !item_s1.button_b, !item_s1.button_a};
				3'd1: begin
					b4  = 1'b0;
					b5  = 1'b0;
					nib = axis_x_q[7:4];
				end
				3'd2: begin
					b5  = 1'b0;
					nib = axis_x_q[3:0];
				end
				3'd3: begin
					b4  = 1'b0;
					b5  = 1'b0;
					nib = axis_y_q[7:4];
				end
				3'd4: begin
					b5  = 1'b0;
					nib = axis_y_q[3:0];
				end
				default: ;
			endcase
		end else begin
			b4 = !item_s1.button_a;
			b5 = !item_s1.button_b;
			if (!port_index_q) begin
				if (item_s1.ctrl_value == CTRL_P0_HI)
					nib = dir[7:4];
				else if (item_s1.ctrl_value == CTRL_P0_LO)
					nib = dir[3:0];
				else
					nib = item_s1.port_dc[3:0];
			end else begin
				if (item_s1.ctrl_value == CTRL_P1_HI)
					nib = dir[7:4];
				else if (item_s1.ctrl_value == CTRL_P1_LO)
					nib = dir[3:0];
				else
					nib = {item_s1.port_dd[1:0], item_s1.port_dc[7:6]};
			end
		end

		if (item_s1.object_id == OBJ_A)
			bit_c = b4;
		else if (item_s1.object_id == OBJ_B)
			bit_c = b5;
		else if (item_s1.object_id > OBJ_RIGHT)
			bit_c = 1'b1;
		else
			bit_c = nib[sel];
	end

endmodule

@@ src/tbp_out_stage.sv @@
module tbp_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic bit_c,
	input  logic out_stall,
	output logic out_free,
	output logic out_valid,
	output logic read_bit
);

	logic out_valid_q;
	logic read_bit_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign read_bit  = read_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_bit_q <= bit_c;
		end
	end

endmodule

@@ src/trackball_pad_port_unit.sv @@
// A read beat is held in the input register, then loaded into the output register.
// Throughput: one beat per cycle unless stalled; a non-read item ends in the input register.
// Only a read waiting on a stalled, full output register holds the input side.
// Reset (arst_n low, asynchronous): axes 0, axis latch 1, strobe clock and phase 0,
// export region, port 0, both stages empty.
module trackball_pad_port_unit
	import tbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [2:0]        object_id,
	input  logic              button_a,
	input  logic              button_b,
	input  logic signed [7:0] move_x,
	input  logic signed [7:0] move_y,
	input  logic [7:0]        ctrl_value,
	input  logic [7:0]        ctrl_prev,
	input  logic [7:0]        port_dc,
	input  logic [7:0]        port_dd,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              read_bit
);

	item_t item_in;
	item_t item_s1;
	logic  fire;
	logic  out_free;
	logic  bit_c;
	logic  load;

	assign item_in = '{
		opcode:     opcode,
		object_id:  object_id,
		button_a:   button_a,
		button_b:   button_b,
		move_x:     move_x,
		move_y:     move_y,
		ctrl_value: ctrl_value,
		ctrl_prev:  ctrl_prev,
		port_dc:    port_dc,
		port_dd:    port_dd
	};

	assign load = fire && (item_s1.opcode == OP_READ);

	tbp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.out_free (out_free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	tbp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item_s1   (item_s1),
		.bit_c     (bit_c)
	);

	tbp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bit_c     (bit_c),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.read_bit  (read_bit)
	);

endmodule

@@ src/tbp_checker.sv @@
`include "trackball_pad_port_unit_assert.svh"

module tbp_checker
	import tbp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] opcode,
	input logic       out_valid,
	input logic       out_stall,
	input logic       read_bit
);

	// input side only backs up behind a full, stalled output
	`TBP_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output backpressure")

	// a read taken into an empty pipe reaches the output once the output is free
	`TBP_ASSERT(a_read_lands, (in_valid && !in_stall && opcode == OP_READ && !out_valid) ##1 !out_stall |=> out_valid, "read beat did not reach the output")

	// held result beat keeps its level
	`TBP_ASSERT(a_hold_bit, (out_valid && out_stall) |=> $stable(read_bit), "stalled result beat changed")

	`TBP_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_valid && !in_stall), "pipeline not empty in reset")

endmodule

bind trackball_pad_port_unit tbp_checker u_tbp_checker (.*);
